// File: hw/rtl/tssr_pkg.sv
// shared constants, types and helpers of the tile and sprite scanline renderer
package tssr_pkg;

    localparam int VRAM_BYTES       = 8192;
    localparam int SPRITE_ENTRIES   = 40;
    localparam int MAX_LINE_SPRITES = 10;
    localparam int LINE_WIDTH       = 256;

    localparam int VRAM_AW     = $clog2(VRAM_BYTES);
    localparam int SPRITE_BYTES = SPRITE_ENTRIES * 4;
    localparam int OAM_AW      = $clog2(SPRITE_BYTES);
    localparam int SPR_IDX_W   = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
    localparam int SEL_CNT_W   = $clog2(MAX_LINE_SPRITES + 1);
    localparam int SEL_IDX_W   = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
    localparam int LB_WORDS    = LINE_WIDTH / 8;
    localparam int LB_AW       = $clog2(LB_WORDS);

    localparam logic [9:0]         DOTS_PER_LINE = 10'd456;
    localparam logic [7:0]         LAST_LINE     = 8'd153;
    localparam logic [7:0]         VBLANK_LINE   = 8'd144;
    localparam logic [VRAM_AW-1:0] MAP_BASE      = VRAM_AW'(16'h1800);

    localparam logic [1:0] KIND_VRAM_WR = 2'd0;
    localparam logic [1:0] KIND_OAM_WR  = 2'd1;
    localparam logic [1:0] KIND_DOTS    = 2'd2;

    localparam logic [1:0] REG_BG_PAL  = 2'd0;
    localparam logic [1:0] REG_SP0_PAL = 2'd1;
    localparam logic [1:0] REG_SP1_PAL = 2'd2;

    typedef struct packed {
        logic [7:0] bg;
        logic [7:0] sp0;
        logic [7:0] sp1;
    } pal_t;

    typedef struct packed {
        logic       start;
        logic [7:0] line;
        logic       vblank;
    } render_cmd_t;

    typedef struct packed {
        logic               vram_we;
        logic               oam_we;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
    } mem_wr_t;

    typedef struct packed {
        logic [VRAM_AW-1:0] vram_addr;
        logic [OAM_AW-1:0]  oam_addr;
    } mem_rd_t;

    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] colour);
        logic [1:0] s;
        case (colour)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/tssr_mem.sv
// video memory and sprite table, one write and one registered read port each
module tssr_mem import tssr_pkg::*; (
    input  logic              aclk,
    input  mem_wr_t           wr,
    input  mem_rd_t           rd,
    output logic [7:0]        vram_rdata,
    output logic [7:0]        oam_rdata
);

    logic [7:0] vram_mem [VRAM_BYTES];
    logic [7:0] oam_mem  [SPRITE_BYTES];

    always_ff @(posedge aclk) begin
        if (wr.vram_we) begin
            vram_mem[wr.addr] <= wr.data;
        end
        vram_rdata <= vram_mem[rd.vram_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.oam_we) begin
            oam_mem[wr.addr[OAM_AW-1:0]] <= wr.data;
        end
        oam_rdata <= oam_mem[rd.oam_addr];
    end

endmodule

// File: hw/rtl/tssr_render.sv
// line render sequencer: background fetch, sprite scan, sprite merge, chunk output
module tssr_render import tssr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  render_cmd_t cmd,
    input  pal_t        pal,
    output logic        idle,
    output mem_rd_t     rd,
    input  logic [7:0]  vram_rdata,
    input  logic [7:0]  oam_rdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_line_number,
    output logic [2:0]  m_chunk_index,
    output logic [63:0] m_pixel_shades,
    output logic        m_vblank_request,
    output logic        m_last_chunk
);

    typedef enum logic [20:0] {
        S_IDLE      = 21'h000001,
        S_BG_MAP    = 21'h000002,
        S_BG_LO     = 21'h000004,
        S_BG_HI     = 21'h000008,
        S_BG_WR     = 21'h000010,
        S_SCAN      = 21'h000020,
        S_SCAN_CHK  = 21'h000040,
        S_SPR_START = 21'h000080,
        S_SPR_Y     = 21'h000100,
        S_SPR_X     = 21'h000200,
        S_SPR_T     = 21'h000400,
        S_SPR_F     = 21'h000800,
        S_SPR_LO    = 21'h001000,
        S_SPR_HI    = 21'h002000,
        S_SPR_RD0   = 21'h004000,
        S_SPR_WR0   = 21'h008000,
        S_SPR_RD1   = 21'h010000,
        S_SPR_WR1   = 21'h020000,
        S_OUT_RD    = 21'h040000,
        S_OUT_ACC   = 21'h080000,
        S_OUT_WAIT  = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]           line_reg;
    logic                 vb_reg;
    logic [LB_AW-1:0]     tile_cnt_reg;
    logic [SPR_IDX_W-1:0] scan_reg;
    logic [SEL_CNT_W-1:0] sel_cnt_reg;
    logic [SEL_CNT_W-1:0] ptr_reg;
    logic [SPR_IDX_W-1:0] sel_list_reg [MAX_LINE_SPRITES];
    logic [7:0]           tile_reg;
    logic [7:0]           lo_reg;
    logic [7:0]           hi_reg;
    logic [7:0]           sy_reg;
    logic [7:0]           sx_reg;
    logic                 pal_sel_reg;
    logic [2:0]           chunk_reg;
    logic [1:0]           sub_reg;
    logic [63:0]          word_reg;
    logic                 m_valid_reg;

    // line buffer: per 8-pixel word, upper half background, lower half final
    logic [31:0]      lb_mem [LB_WORDS];
    logic [31:0]      lb_rdata;
    logic             lb_we;
    logic [LB_AW-1:0] lb_waddr;
    logic [31:0]      lb_wdata;
    logic [LB_AW-1:0] lb_raddr;

    always_ff @(posedge aclk) begin
        if (lb_we) begin
            lb_mem[lb_waddr] <= lb_wdata;
        end
        lb_rdata <= lb_mem[lb_raddr];
    end

    // sprite geometry
    logic [8:0]       spr_base;
    logic [LB_AW-1:0] w0;
    logic [LB_AW-1:0] w1;
    logic [2:0]       spr_off;
    logic             w0_ok;
    logic             w1_ok;
    logic [2:0]       spr_row;
    logic [SPR_IDX_W-1:0] cur_spr;
    logic [8:0]       y_lo;
    logic [8:0]       y_hi;
    logic             y_hit;

    assign spr_base = {1'b0, sx_reg} - 9'd8;
    assign w0       = spr_base[LB_AW+2:3];
    assign w1       = w0 + 1'b1;
    assign spr_off  = spr_base[2:0];
    assign w0_ok    = !spr_base[8];
    assign w1_ok    = (spr_off != 3'd0);
    assign spr_row  = line_reg[2:0] - sy_reg[2:0];
    assign cur_spr  = sel_list_reg[ptr_reg[SEL_IDX_W-1:0]];
    assign y_lo     = {1'b0, line_reg} + 9'd9;
    assign y_hi     = {1'b0, line_reg} + 9'd16;
    assign y_hit    = ({1'b0, oam_rdata} >= y_lo) && ({1'b0, oam_rdata} <= y_hi);

    // background shades of one tile row
    logic [15:0] bg_shades;
    always_comb begin
        for (int p = 0; p < 8; p++) begin
            bg_shades[2*p +: 2] = shade_of(pal.bg, {vram_rdata[7-p], lo_reg[7-p]});
        end
    end

    // sprite merge into one line buffer word
    logic [15:0] merged;
    logic [7:0]  spal;
    always_comb begin
        logic [3:0] s;
        logic [4:0] d;
        logic [2:0] j;
        logic [1:0] c;
        spal = pal_sel_reg ? pal.sp1 : pal.sp0;
        for (int p = 0; p < 8; p++) begin
            s = {(state_reg == S_SPR_WR1), 3'(p)};
            d = {1'b0, s} - {2'b00, spr_off};
            j = 3'd7 - d[2:0];
            c = {hi_reg[j], lo_reg[j]};
            if (d[4:3] == 2'b00) begin
                merged[2*p +: 2] = (c != 2'd0) ? shade_of(spal, c) : lb_rdata[16+2*p +: 2];
            end else begin
                merged[2*p +: 2] = lb_rdata[2*p +: 2];
            end
        end
    end

    // read addresses, line buffer write and next state
    always_comb begin
        state_next   = state_reg;
        rd.vram_addr = '0;
        rd.oam_addr  = '0;
        lb_we        = 1'b0;
        lb_waddr     = tile_cnt_reg;
        lb_wdata     = {bg_shades, bg_shades};
        lb_raddr     = {chunk_reg, sub_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.start) state_next = S_BG_MAP;
            end
            S_BG_MAP: begin
                rd.vram_addr = MAP_BASE + VRAM_AW'({line_reg[7:3], tile_cnt_reg});
                state_next   = S_BG_LO;
            end
            S_BG_LO: begin
                rd.vram_addr = {1'b0, vram_rdata, line_reg[2:0], 1'b0};
                state_next   = S_BG_HI;
            end
            S_BG_HI: begin
                rd.vram_addr = {1'b0, tile_reg, line_reg[2:0], 1'b1};
                state_next   = S_BG_WR;
            end
            S_BG_WR: begin
                lb_we      = 1'b1;
                state_next = (tile_cnt_reg == LB_AW'(LB_WORDS - 1)) ? S_SCAN : S_BG_MAP;
            end
            S_SCAN: begin
                rd.oam_addr = {scan_reg, 2'd0};
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                state_next = (scan_reg == SPR_IDX_W'(SPRITE_ENTRIES - 1)) ? S_SPR_START
                                                                          : S_SCAN;
            end
            S_SPR_START: begin
                rd.oam_addr = {cur_spr, 2'd0};
                state_next  = (ptr_reg == sel_cnt_reg) ? S_OUT_RD : S_SPR_Y;
            end
            S_SPR_Y: begin
                rd.oam_addr = {cur_spr, 2'd1};
                state_next  = S_SPR_X;
            end
            S_SPR_X: begin
                rd.oam_addr = {cur_spr, 2'd2};
                state_next  = S_SPR_T;
            end
            S_SPR_T: begin
                rd.oam_addr = {cur_spr, 2'd3};
                state_next  = S_SPR_F;
            end
            S_SPR_F: begin
                rd.vram_addr = {1'b0, tile_reg, spr_row, 1'b0};
                state_next   = S_SPR_LO;
            end
            S_SPR_LO: begin
                rd.vram_addr = {1'b0, tile_reg, spr_row, 1'b1};
                state_next   = S_SPR_HI;
            end
            S_SPR_HI: begin
                state_next = S_SPR_RD0;
            end
            S_SPR_RD0: begin
                lb_raddr   = w0;
                state_next = w0_ok ? S_SPR_WR0 : S_SPR_RD1;
            end
            S_SPR_WR0: begin
                lb_we      = 1'b1;
                lb_waddr   = w0;
                lb_wdata   = {lb_rdata[31:16], merged};
                state_next = S_SPR_RD1;
            end
            S_SPR_RD1: begin
                lb_raddr   = w1;
                state_next = w1_ok ? S_SPR_WR1 : S_SPR_START;
            end
            S_SPR_WR1: begin
                lb_we      = 1'b1;
                lb_waddr   = w1;
                lb_wdata   = {lb_rdata[31:16], merged};
                state_next = S_SPR_START;
            end
            S_OUT_RD: begin
                state_next = S_OUT_ACC;
            end
            S_OUT_ACC: begin
                state_next = (sub_reg == 2'd3) ? S_OUT_WAIT : S_OUT_RD;
            end
            S_OUT_WAIT: begin
                if (m_ready) state_next = (chunk_reg == 3'd7) ? S_IDLE : S_OUT_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            tile_cnt_reg <= '0;
            scan_reg     <= '0;
            sel_cnt_reg  <= '0;
            ptr_reg      <= '0;
            chunk_reg    <= '0;
            sub_reg      <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    tile_cnt_reg <= '0;
                    scan_reg     <= '0;
                    sel_cnt_reg  <= '0;
                    ptr_reg      <= '0;
                    chunk_reg    <= '0;
                    sub_reg      <= '0;
                end
                S_BG_WR: tile_cnt_reg <= tile_cnt_reg + 1'b1;
                S_SCAN_CHK: begin
                    scan_reg <= scan_reg + 1'b1;
                    if (y_hit && sel_cnt_reg < SEL_CNT_W'(MAX_LINE_SPRITES)) begin
                        sel_cnt_reg <= sel_cnt_reg + 1'b1;
                    end
                end
                S_SPR_RD1: if (!w1_ok) ptr_reg <= ptr_reg + 1'b1;
                S_SPR_WR1: ptr_reg <= ptr_reg + 1'b1;
                S_OUT_ACC: begin
                    sub_reg <= sub_reg + 1'b1;
                    if (sub_reg == 2'd3) m_valid_reg <= 1'b1;
                end
                S_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        chunk_reg   <= chunk_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && cmd.start) begin
            line_reg <= cmd.line;
            vb_reg   <= cmd.vblank;
        end
        if (state_reg == S_BG_LO) tile_reg <= vram_rdata;
        if (state_reg == S_SPR_T) tile_reg <= oam_rdata;
        if (state_reg == S_BG_HI || state_reg == S_SPR_LO) lo_reg <= vram_rdata;
        if (state_reg == S_SPR_HI) hi_reg <= vram_rdata;
        if (state_reg == S_SPR_Y) sy_reg <= oam_rdata;
        if (state_reg == S_SPR_X) sx_reg <= oam_rdata;
        if (state_reg == S_SPR_F) pal_sel_reg <= oam_rdata[4];
        if (state_reg == S_SCAN_CHK && y_hit
                && sel_cnt_reg < SEL_CNT_W'(MAX_LINE_SPRITES)) begin
            sel_list_reg[sel_cnt_reg[SEL_IDX_W-1:0]] <= scan_reg;
        end
        if (state_reg == S_OUT_ACC) word_reg <= {lb_rdata[15:0], word_reg[63:16]};
    end

    assign idle             = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_line_number    = line_reg;
    assign m_chunk_index    = chunk_reg;
    assign m_pixel_shades   = word_reg;
    assign m_vblank_request = vb_reg;
    assign m_last_chunk     = (chunk_reg == 3'd7);

    a_valid_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == S_OUT_WAIT) else $error("result shown outside wait");
    a_sel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_cnt_reg <= SEL_CNT_W'(MAX_LINE_SPRITES)) else $error("sprite list overflow");
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= sel_cnt_reg) else $error("sprite pointer past list");
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_chunk) |=> idle) else $error("line did not end");

endmodule

// File: hw/rtl/tile_sprite_scanline_renderer.sv
// top level: input beats, dot and line counters, palettes, memories and renderer
//
// Tile and sprite scanline renderer. Input beats write video memory (kind 0),
// write the sprite table (kind 1, bytes at or above 160 are dropped) or add dots
// (kind 2). When the dot count reaches 456 the counter clears, excess dots are
// dropped and the current line is rendered into eight result beats of 32 pixels
// each, chunk 0 first. A dot beat that ends a line keeps the input side closed
// until the last result beat is taken: the render runs through memories with
// registered reads and fetches the background (four accesses per tile over 32
// tiles), scans all 40 sprite table entries, merges up to 10 selected sprites
// into the line buffer and sends the result beats, which the output can stall.
// The user must write the palette registers on the plain write port only while
// the block is idle; the block itself does not enforce this.
module tile_sprite_scanline_renderer import tssr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [12:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_dot_count,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_line_number,
    output logic [2:0]  m_chunk_index,
    output logic [63:0] m_pixel_shades,
    output logic        m_vblank_request,
    output logic        m_last_chunk
);

    pal_t        pal_reg;
    logic [9:0]  dot_cnt_reg, dot_cnt_next;
    logic [7:0]  line_reg, line_next;
    logic [9:0]  dot_sum;
    logic        s_beat;
    logic        line_done;
    logic        idle;
    render_cmd_t cmd;
    mem_wr_t     wr;
    mem_rd_t     rd;
    logic [7:0]  vram_rdata;
    logic [7:0]  oam_rdata;

    assign s_ready   = idle;
    assign s_beat    = s_valid && s_ready;
    assign dot_sum   = dot_cnt_reg + {2'b00, s_dot_count};
    assign line_done = s_beat && (s_kind == KIND_DOTS) && (dot_sum >= DOTS_PER_LINE);

    // memory writes straight from the input beat
    assign wr.vram_we = s_beat && (s_kind == KIND_VRAM_WR);
    assign wr.oam_we  = s_beat && (s_kind == KIND_OAM_WR)
                        && (s_address < 13'(SPRITE_BYTES));
    assign wr.addr    = s_address;
    assign wr.data    = s_write_data;

    // vblank flags the line whose end moves the counter onto line 144
    assign cmd.start  = line_done;
    assign cmd.line   = line_reg;
    assign cmd.vblank = (line_reg == VBLANK_LINE - 8'd1);

    always_comb begin
        dot_cnt_next = dot_cnt_reg;
        line_next    = line_reg;
        if (s_beat && s_kind == KIND_DOTS) begin
            dot_cnt_next = line_done ? 10'd0 : dot_sum;
        end
        if (line_done) begin
            line_next = (line_reg == LAST_LINE) ? 8'd0 : line_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_cnt_reg <= '0;
            line_reg    <= '0;
            pal_reg.bg  <= 8'd252;
            pal_reg.sp0 <= 8'd255;
            pal_reg.sp1 <= 8'd255;
        end else begin
            dot_cnt_reg <= dot_cnt_next;
            line_reg    <= line_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_BG_PAL:  pal_reg.bg  <= cfg_wr_data;
                    REG_SP0_PAL: pal_reg.sp0 <= cfg_wr_data;
                    REG_SP1_PAL: pal_reg.sp1 <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    tssr_mem u_mem (
        .aclk       (aclk),
        .wr         (wr),
        .rd         (rd),
        .vram_rdata (vram_rdata),
        .oam_rdata  (oam_rdata)
    );

    tssr_render u_render (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .pal              (pal_reg),
        .idle             (idle),
        .rd               (rd),
        .vram_rdata       (vram_rdata),
        .oam_rdata        (oam_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_number    (m_line_number),
        .m_chunk_index    (m_chunk_index),
        .m_pixel_shades   (m_pixel_shades),
        .m_vblank_request (m_vblank_request),
        .m_last_chunk     (m_last_chunk)
    );

    a_dot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dot_cnt_reg < DOTS_PER_LINE) else $error("dot counter past line end");
    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg <= LAST_LINE) else $error("line counter past last line");
    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        line_done |=> !s_ready) else $error("input open during render");

endmodule
